// File: src/safs_pkg.sv
package safs_pkg;

	localparam int SLOT_W = 10;
	localparam int CAP_W  = 11;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK              = 2'd0,
		ST_EXHAUSTED       = 2'd1,
		ST_NEVER_ALLOCATED = 2'd2,
		ST_DOUBLE_FREE     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

// File: src/safs_if.sv
interface safs_req_if import safs_pkg::*;;
	logic                valid;
	logic                ready;
	action_t             action;
	logic [SLOT_W-1:0]   slot_id;

	modport source (output valid, action, slot_id, input ready);
	modport sink (input valid, action, slot_id, output ready);
endinterface

interface safs_rsp_if import safs_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   granted_slot;
	status_t             status;

	modport source (output valid, granted_slot, status, input ready);
	modport sink (input valid, granted_slot, status, output ready);
endinterface

// File: src/safs_ctrl.sv
module safs_ctrl import safs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					cmd.execute = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/safs_dp.sv
module safs_dp import safs_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_stat_t          stat,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,
	input  action_t           in_action,
	input  logic [SLOT_W-1:0] in_slot_id,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] out_granted_slot,
	output status_t           out_status
);

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];
	logic              free_mem  [MAX_SLOTS];

	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [CAP_W-1:0]  cap_q;
	action_t           action_q;
	logic [SLOT_W-1:0] id_q;
	logic [SLOT_W-1:0] stk_rd_q;
	logic              free_rd_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	status_t           out_status_q;

	logic [CNT_W-1:0]  depth_m1;
	logic [CNT_W-1:0]  depth_d;
	logic [CNT_W-1:0]  fresh_d;
	logic              stk_we;
	logic [IDX_W-1:0]  stk_waddr;
	logic              free_we;
	logic [IDX_W-1:0]  free_waddr;
	logic              free_wdata;
	logic [SLOT_W-1:0] granted;
	status_t           status;
	logic              exhausted;
	logic              never_alloc;

	assign depth_m1 = depth_q - 1'b1;

	// read stack top and the free bit of the requested id on accept
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= in_action;
			id_q      <= in_slot_id;
			stk_rd_q  <= stack_mem[depth_m1[IDX_W-1:0]];
			free_rd_q <= free_mem[IDX_W'(in_slot_id)];
		end
	end

	assign exhausted = (CMP_W'(fresh_q) >= CMP_W'(cap_q))
		|| (CMP_W'(fresh_q) >= CMP_W'(MAX_SLOTS));
	assign never_alloc = CMP_W'(id_q) >= CMP_W'(fresh_q);

	always_comb begin
		depth_d    = depth_q;
		fresh_d    = fresh_q;
		stk_we     = 1'b0;
		stk_waddr  = depth_q[IDX_W-1:0];
		free_we    = 1'b0;
		free_waddr = IDX_W'(id_q);
		free_wdata = 1'b0;
		granted    = '0;
		status     = ST_OK;
		case (action_q)
			ACT_ALLOC: begin
				if (depth_q != '0) begin
					// pop the most recently freed slot
					depth_d    = depth_m1;
					granted    = stk_rd_q;
					free_we    = 1'b1;
					free_waddr = IDX_W'(stk_rd_q);
				end else if (exhausted) begin
					status = ST_EXHAUSTED;
				end else begin
					// first hand-out of a slot also initializes its free bit
					granted    = SLOT_W'(fresh_q);
					fresh_d    = fresh_q + 1'b1;
					free_we    = 1'b1;
					free_waddr = IDX_W'(fresh_q);
				end
			end
			ACT_FREE: begin
				if (never_alloc) begin
					status = ST_NEVER_ALLOCATED;
				end else if (free_rd_q) begin
					status = ST_DOUBLE_FREE;
				end else if (CMP_W'(depth_q) < CMP_W'(MAX_SLOTS)) begin
					stk_we     = 1'b1;
					depth_d    = depth_q + 1'b1;
					free_we    = 1'b1;
					free_wdata = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && stk_we) begin
			stack_mem[stk_waddr] <= id_q;
		end
		if (cmd.execute && free_we) begin
			free_mem[free_waddr] <= free_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			fresh_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.execute) begin
				depth_q     <= depth_d;
				fresh_q     <= fresh_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			out_slot_q   <= granted;
			out_status_q <= status;
		end
	end

	assign stat.out_free     = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign out_granted_slot  = out_slot_q;
	assign out_status        = out_status_q;

endmodule

// File: src/slot_allocator_free_stack_top.sv
// Flow: an accepted request beat is captured together with the free stack top and
// the free bit of its id (registered read); the decision and write-back of both
// then wait until the output register is free or being drained, and the result
// beat is held in that output register. A new request is taken only after the last
// one has been executed, and a held result beat stalls the write-back.
// Reset (arst_n low): stack depth and fresh-slot counter clear, capacity returns
// to 1024; no clearing pass, as a slot's free bit is written when first granted.
module slot_allocator_free_stack_top import safs_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	safs_req_if.sink         req,
	safs_rsp_if.source       rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Controller: one request in flight; accept in idle, execute once the
	// output register is free or being drained.
	safs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: free stack and free bitmap memories, depth and bump counters,
	// capacity register and the output register that holds the result beat.
	safs_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_action        (req.action),
		.in_slot_id       (req.slot_id),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_granted_slot (rsp.granted_slot),
		.out_status       (rsp.status)
	);

	// an executed request always produces a result beat in the next cycle
	a_exec_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> rsp.valid)
		else $error("executed request produced no result beat");

	// never overwrite a result beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> (!rsp.valid || rsp.ready))
		else $error("result register overwritten while held");

	// one request at a time: no new beat taken right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// a capture and an execute never happen in the same cycle
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.execute))
		else $error("capture and execute asserted together");

endmodule

// File: tb/slot_allocator_free_stack_top_tb.sv
module slot_allocator_free_stack_top_tb import safs_pkg::*;;

	localparam int MAX_SLOTS = 1024;
	// Stop the run long after the slowest legal schedule would have finished.
	localparam int RUN_LIMIT = 10_000_000;

	// One expected result beat: what the allocator should answer for a request.
	typedef struct {
		logic [SLOT_W-1:0] granted_slot;
		status_t           status;
	} grant_t;

	// Shadow of the allocator: free stack, bump counter, per-slot free bits
	// and the capacity register, plus the queue of answers still owed.
	class slot_shadow;
		logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];
		bit                on_stack  [MAX_SLOTS];
		int unsigned       depth;
		int unsigned       fresh;
		logic [CAP_W-1:0]  capacity;
		grant_t            pending_grants [$];
		int                errors;

		function new();
			depth    = 0;
			fresh    = 0;
			capacity = CAP_RESET;
			errors   = 0;
			foreach (on_stack[i])
				on_stack[i] = 1'b0;
		endfunction

		// Advance the shadow by one accepted request and queue its answer.
		function void note_request(action_t act, logic [SLOT_W-1:0] id);
			grant_t      ans;
			int unsigned cap_limit;
			cap_limit        = (capacity > MAX_SLOTS) ? MAX_SLOTS : capacity;
			ans.granted_slot = '0;
			ans.status       = ST_OK;
			if (act == ACT_ALLOC) begin
				if (depth > 0) begin
					depth--;
					ans.granted_slot = stack_mem[depth];
					on_stack[ans.granted_slot] = 1'b0;
				end else if (fresh >= cap_limit) begin
					ans.status = ST_EXHAUSTED;
				end else begin
					ans.granted_slot = SLOT_W'(fresh);
					fresh++;
				end
			end else begin
				if (id >= fresh) begin
					ans.status = ST_NEVER_ALLOCATED;
				end else if (on_stack[id]) begin
					ans.status = ST_DOUBLE_FREE;
				end else if (depth < MAX_SLOTS) begin
					stack_mem[depth] = id;
					depth++;
					on_stack[id] = 1'b1;
				end
			end
			pending_grants = {pending_grants, ans};
		endfunction

		// Compare one result beat with the oldest answer owed.
		function void check_result(logic [SLOT_W-1:0] granted, status_t st);
			grant_t ans;
			if (pending_grants.size() == 0) begin
				$error("result beat with no request pending: granted_slot %0d status %0d",
					granted, st);
				errors++;
				return;
			end
			ans = pending_grants.pop_front();
			if (granted !== ans.granted_slot) begin
				$error("granted_slot mismatch: expected %0d, actual %0d",
					ans.granted_slot, granted);
				errors++;
			end
			if (st !== ans.status) begin
				$error("status mismatch: expected %0d, actual %0d", ans.status, st);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	safs_req_if req_if ();
	safs_rsp_if rsp_if ();

	slot_shadow shadow;

	// Percent of cycles in which the sender holds off / the receiver stalls.
	int src_idle_pct;
	int sink_stall_pct;

	slot_allocator_free_stack_top #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#RUN_LIMIT;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: decide ready on every falling edge, stalling at the phase's rate.
	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Monitor both channels at the rising edge. Check the result beat first: it is
	// registered after its request is captured, so it always belongs to an earlier request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
				shadow.check_result(rsp_if.granted_slot, rsp_if.status);
			if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
				shadow.note_request(req_if.action, req_if.slot_id);
		end
	end

	// Present one request beat and hold it until accepted. Enter and leave on a
	// falling edge; valid stays high on return so back-to-back beats never glitch.
	task automatic send_req(action_t act, logic [SLOT_W-1:0] id);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.action  <= act;
		req_if.slot_id <= id;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and hold until every owed result has come back.
	task automatic drain_grants();
		req_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (shadow.pending_grants.size() != 0);
	endtask

	// Write the capacity register only while the allocator is idle.
	task automatic write_capacity(logic [CAP_W-1:0] value);
		drain_grants();
		repeat (3) @(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow.capacity = value;
	endtask

	// Random traffic: mostly allocates and frees of slots currently handed out,
	// with some noise frees (random ids, slots already back on the stack).
	task automatic run_phase(int n_items, int alloc_pct);
		int          roll;
		int unsigned pick;
		int          tries;
		repeat (n_items) begin
			roll = $urandom_range(99);
			if (roll < alloc_pct) begin
				// slot_id is ignored on allocate; randomize it anyway
				send_req(ACT_ALLOC, SLOT_W'($urandom));
			end else if (roll < alloc_pct + (100 - alloc_pct) * 4 / 5 &&
					shadow.fresh > shadow.depth) begin
				// hunt for a slot that is out on loan
				pick  = $urandom_range(shadow.fresh - 1);
				tries = 0;
				while (shadow.on_stack[pick] && tries < 16) begin
					pick = $urandom_range(shadow.fresh - 1);
					tries++;
				end
				send_req(ACT_FREE, SLOT_W'(pick));
			end else if (shadow.depth > 0 && $urandom_range(1) == 1) begin
				// free a slot that already sits on the stack
				send_req(ACT_FREE, shadow.stack_mem[$urandom_range(shadow.depth - 1)]);
			end else begin
				send_req(ACT_FREE, SLOT_W'($urandom));
			end
		end
	endtask

	initial begin
		shadow         = new();
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = CAP_RESET;
		req_if.valid   = 1'b0;
		req_if.action  = ACT_ALLOC;
		req_if.slot_id = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, default capacity. Free before anything was handed out.
		send_req(ACT_FREE, 10'd0);
		send_req(ACT_FREE, 10'h3ff);
		// Fresh slots come from the bump counter.
		send_req(ACT_ALLOC, 10'h3ff);
		send_req(ACT_ALLOC, 10'd0);
		send_req(ACT_ALLOC, 10'd0);
		// Free, then double free, then LIFO reuse.
		send_req(ACT_FREE, 10'd1);
		send_req(ACT_FREE, 10'd1);
		send_req(ACT_FREE, 10'd0);
		send_req(ACT_ALLOC, 10'd0);
		send_req(ACT_ALLOC, 10'd0);
		// Id above the counter was never handed out.
		send_req(ACT_FREE, 10'd3);
		send_req(ACT_FREE, 10'd2);

		// Zero capacity: the stack still serves, then the pool is exhausted.
		write_capacity(11'd0);
		send_req(ACT_ALLOC, 10'd0);
		send_req(ACT_ALLOC, 10'd0);
		send_req(ACT_FREE, 10'd0);
		send_req(ACT_ALLOC, 10'd0);

		// Capacity lowered below the counter.
		write_capacity(11'd2);
		send_req(ACT_ALLOC, 10'd0);

		// Capacity above the pool size saturates.
		write_capacity(11'h7ff);
		send_req(ACT_ALLOC, 10'd0);
		send_req(ACT_ALLOC, 10'd0);
		send_req(ACT_FREE, 10'h3ff);

		write_capacity(11'd5);
		send_req(ACT_ALLOC, 10'd0);
		send_req(ACT_FREE, 10'd4);
		send_req(ACT_FREE, 10'd3);
		send_req(ACT_ALLOC, 10'd0);

		// Random phases. No idling on either side.
		write_capacity(CAP_RESET);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		run_phase(400, 65);

		// Sender mostly idle; small pool so exhaustion shows up often.
		write_capacity(11'd300);
		src_idle_pct = 74;
		run_phase(200, 75);
		// Hold the sender until every result is back, then resume.
		drain_grants();
		run_phase(200, 75);

		// Receiver mostly stalling; saturated capacity, allocation heavy.
		write_capacity(11'h7ff);
		src_idle_pct   = 0;
		sink_stall_pct = 74;
		run_phase(400, 92);

		// Both sides idle now and then; fill further, then drain into the stack.
		write_capacity(CAP_RESET);
		src_idle_pct   = 37;
		sink_stall_pct = 37;
		run_phase(250, 80);
		run_phase(150, 30);

		drain_grants();
		repeat (8) @(negedge clk);
		if (shadow.errors == 0 && shadow.pending_grants.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
